// ===== hw/rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// shared widths, constants and register codes of the link stability scorer
// ----------------------------------------------------------------------------
package lss_pkg;

	// field widths
	localparam int POS_W   = 24;
	localparam int VEL_W   = 20;
	localparam int RANGE_W = 23;
	localparam int SPEED_W = 19;
	localparam int POWER_W = 4;
	localparam int CFG_W   = 23;
	localparam int SCORE_W = 17;

	// q16 unity
	localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;

	// squared lengths and limits
	localparam int D2_W  = 50;
	localparam int W2_W  = 42;
	localparam int DEN_W = 46;

	// ratio unit: one quotient bit a stage, then one root bit a stage
	localparam int QUO_W      = 32;
	localparam int ROOT_W     = QUO_W / 2;
	localparam int RATIO_LAT  = 1 + QUO_W + ROOT_W + 1;

	// one stage per possible exponent step
	localparam int POW_STAGES = 15;

	// register indexes
	localparam logic [1:0] REG_RANGE_LIMIT = 2'd0;
	localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
	localparam logic [1:0] REG_RANGE_POWER = 2'd2;

endpackage

// ===== hw/rtl/lss_ratio.sv =====
// ----------------------------------------------------------------------------
// lss_ratio
// pipelined floor(sqrt(num/den) * 65536), saturated to 65536
// ----------------------------------------------------------------------------
module lss_ratio (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lss_pkg::D2_W-1:0]    num,
	input  logic [lss_pkg::DEN_W-1:0]   den,
	output logic [lss_pkg::SCORE_W-1:0] ratio
);

	localparam int QW = lss_pkg::QUO_W;
	localparam int RW = lss_pkg::ROOT_W;
	localparam int DW = lss_pkg::DEN_W;
	localparam int SCORE_W_L = lss_pkg::SCORE_W;

	// entry and restoring division stages
	logic [DW-1:0] dv_rem_s [QW+1];
	logic [DW-1:0] dv_den_s [QW+1];
	logic [QW-1:0] dv_q_s   [QW+1];
	logic          dv_sat_s [QW+1];

	// square root stages
	logic [RW+1:0] sq_rem_s [RW];
	logic [RW-1:0] sq_res_s [RW];
	logic [QW-1:0] sq_rad_s [RW];
	logic          sq_sat_s [RW];

	logic [SCORE_W_L-1:0] ratio_s;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sat_s[0] <= (den == '0) || (num >= {{(lss_pkg::D2_W-DW){1'b0}}, den});
			dv_rem_s[0] <= num[DW-1:0];
			dv_den_s[0] <= den;
			dv_q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic [DW:0] rem2;
		logic        ge;
		assign rem2 = {dv_rem_s[j-1], 1'b0};
		assign ge   = rem2 >= {1'b0, dv_den_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j] <= ge ? DW'(rem2 - {1'b0, dv_den_s[j-1]}) : rem2[DW-1:0];
				dv_den_s[j] <= dv_den_s[j-1];
				dv_q_s[j]   <= {dv_q_s[j-1][QW-2:0], ge};
				dv_sat_s[j] <= dv_sat_s[j-1];
			end
		end
	end

	for (genvar i = 0; i < RW; i++) begin : g_root
		logic [RW+1:0] rem_in;
		logic [RW-1:0] res_in;
		logic [QW-1:0] rad_in;
		logic          sat_in;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign res_in = '0;
			assign rad_in = dv_q_s[QW];
			assign sat_in = dv_sat_s[QW];
		end else begin : g_next
			assign rem_in = sq_rem_s[i-1];
			assign res_in = sq_res_s[i-1];
			assign rad_in = sq_rad_s[i-1];
			assign sat_in = sq_sat_s[i-1];
		end
		assign cur   = {rem_in[RW-1:0], rad_in[QW-1 -: 2]};
		assign trial = {res_in, 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i] <= ge ? (cur - trial) : cur;
				sq_res_s[i] <= {res_in[RW-2:0], ge};
				sq_rad_s[i] <= {rad_in[QW-3:0], 2'b00};
				sq_sat_s[i] <= sat_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s <= sq_sat_s[RW-1] ? lss_pkg::ONE_Q16 : {1'b0, sq_res_s[RW-1]};
		end
	end

	assign ratio = ratio_s;

endmodule

// ===== hw/rtl/link_stability_score.sv =====
// ----------------------------------------------------------------------------
// link_stability_score
// scores how long a link to a neighbour is likely to hold, from 3-d positions
// and velocities of both nodes
// ----------------------------------------------------------------------------
// One beat on the slave side holds own and neighbour position and velocity;
// one beat on the master side returns the score in q1.16 (65536 is one) and
// the diverging flag. A new beat is taken every cycle while s_tready is high;
// each beat runs through the input stages, then the two ratio units side by
// side (one quotient bit per stage for 32 stages, then one root bit per stage
// for 16), then one stage per possible exponent step and a final stage, and
// then waits in the output buffer.
// A two-entry output buffer lets the pipeline keep accepting beats while a
// result waits; only when that buffer is full and a result is due does
// s_tready drop. Registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while no beat is in flight, which the block
// does not enforce; range_power values up to 15 are honoured.
// ----------------------------------------------------------------------------
module link_stability_score (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [22:0]  cfg_wdata,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// own_px, own_py, own_pz, own_vx, own_vy, own_vz,
	// peer_px, peer_py, peer_pz, peer_vx, peer_vy, peer_vz
	input  logic [263:0] s_tdata,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// score, moving_apart, zero fill
	output logic [23:0]  m_tdata
);

	localparam int PW  = lss_pkg::POS_W;
	localparam int VW  = lss_pkg::VEL_W;
	localparam int SW  = lss_pkg::SCORE_W;
	localparam int RL  = lss_pkg::RATIO_LAT;
	localparam int NP  = lss_pkg::POW_STAGES;
	localparam int RES_W = SW + 1;

	// field offsets in the slave beat
	localparam int OWN_P  = 0;
	localparam int OWN_V  = 3 * PW;
	localparam int PEER_P = 3 * PW + 3 * VW;
	localparam int PEER_V = 6 * PW + 3 * VW;

	// configuration registers
	logic [lss_pkg::RANGE_W-1:0] range_limit_q;
	logic [lss_pkg::SPEED_W-1:0] speed_limit_q;
	logic [lss_pkg::POWER_W-1:0] range_power_q;
	logic [lss_pkg::DEN_W-1:0]   rng_sq_q;
	logic [lss_pkg::DEN_W-1:0]   spd_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= 23'd4000;
			speed_limit_q <= 19'd1280;
			range_power_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lss_pkg::REG_RANGE_LIMIT: range_limit_q <= cfg_wdata;
				lss_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg_wdata[lss_pkg::SPEED_W-1:0];
				lss_pkg::REG_RANGE_POWER: range_power_q <= cfg_wdata[lss_pkg::POWER_W-1:0];
				default: ;
			endcase
		end
	end

	// squared limits, (2*vmax)^2 for the speed side
	always_ff @(posedge clk) begin
		rng_sq_q <= range_limit_q * range_limit_q;
		spd_sq_q <= {(lss_pkg::DEN_W-2)'(speed_limit_q) * (lss_pkg::DEN_W-2)'(speed_limit_q),
		             2'b00};
	end

	// flow control: the whole pipe moves unless a result is due and the buffer is full
	logic [1:0]       obuf_cnt_q;
	logic [RES_W-1:0] obuf_q [2];
	logic             fin_v_s;
	logic [SW-1:0]    fin_score_s;
	logic             fin_apart_s;
	logic             en;
	logic             push;
	logic             pop;

	assign en       = (obuf_cnt_q != 2'd2) || !fin_v_s;
	assign s_tready = en;

	// stage 1: displacement and relative velocity
	logic                 v_s1;
	logic signed [PW:0]   d_s1 [3];
	logic signed [VW:0]   w_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= (PW+1)'($signed(s_tdata[OWN_P + i*PW +: PW]))
				         - (PW+1)'($signed(s_tdata[PEER_P + i*PW +: PW]));
				w_s1[i] <= (VW+1)'($signed(s_tdata[OWN_V + i*VW +: VW]))
				         - (VW+1)'($signed(s_tdata[PEER_V + i*VW +: VW]));
			end
		end
	end

	// stage 2: squares and cross products
	logic                  v_s2;
	logic [2*PW:0]         dd_s2 [3];
	logic [2*VW:0]         ww_s2 [3];
	logic signed [PW+VW+1:0] dw_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= (2*PW+1)'(d_s1[i] * d_s1[i]);
				ww_s2[i] <= (2*VW+1)'(w_s1[i] * w_s1[i]);
				dw_s2[i] <= (PW+VW+2)'(d_s1[i] * w_s1[i]);
			end
		end
	end

	// stage 3: squared lengths and the diverging test
	logic                    v_s3;
	logic [lss_pkg::D2_W-1:0] d2_s3;
	logic [lss_pkg::W2_W-1:0] w2_s3;
	logic                    apart_s3;
	logic signed [PW+VW+3:0] dot;

	assign dot = (PW+VW+4)'(dw_s2[0]) + (PW+VW+4)'(dw_s2[1]) + (PW+VW+4)'(dw_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3    <= lss_pkg::D2_W'(dd_s2[0]) + lss_pkg::D2_W'(dd_s2[1])
			          + lss_pkg::D2_W'(dd_s2[2]);
			w2_s3    <= lss_pkg::W2_W'(ww_s2[0]) + lss_pkg::W2_W'(ww_s2[1])
			          + lss_pkg::W2_W'(ww_s2[2]);
			apart_s3 <= dot > 0;
		end
	end

	// ratio units, distance and speed side by side
	logic [SW-1:0] rng_ratio;
	logic [SW-1:0] spd_ratio;

	lss_ratio u_rng_ratio (
		.clk   (clk),
		.en    (en),
		.num   (d2_s3),
		.den   (rng_sq_q),
		.ratio (rng_ratio)
	);

	lss_ratio u_spd_ratio (
		.clk   (clk),
		.en    (en),
		.num   (lss_pkg::D2_W'(w2_s3)),
		.den   (spd_sq_q),
		.ratio (spd_ratio)
	);

	// valid and diverging flag ride alongside the ratio units
	logic rt_v_s     [RL];
	logic rt_apart_s [RL];

	always_ff @(posedge clk) begin
		if (en) begin
			rt_apart_s[0] <= apart_s3;
			for (int j = 1; j < RL; j++) begin
				rt_apart_s[j] <= rt_apart_s[j-1];
			end
		end
	end

	// exponent stages: acc <- acc * r >> 16 while the step is below range_power
	logic          pw_v_s     [NP];
	logic [SW-1:0] pw_acc_s   [NP];
	logic [SW-1:0] pw_r_s     [NP];
	logic [SW-1:0] pw_y_s     [NP];
	logic          pw_apart_s [NP];

	for (genvar k = 0; k < NP; k++) begin : g_pow
		logic [SW-1:0]     acc_in;
		logic [SW-1:0]     r_in;
		logic [SW-1:0]     y_in;
		logic              apart_in;
		logic [2*SW-1:0]   prod;
		if (k == 0) begin : g_first
			assign acc_in   = lss_pkg::ONE_Q16;
			assign r_in     = rng_ratio;
			assign apart_in = rt_apart_s[RL-1];
			assign y_in     = rt_apart_s[RL-1] ? SW'(lss_pkg::ONE_Q16 - spd_ratio)
			                                   : lss_pkg::ONE_Q16;
		end else begin : g_next
			assign acc_in   = pw_acc_s[k-1];
			assign r_in     = pw_r_s[k-1];
			assign apart_in = pw_apart_s[k-1];
			assign y_in     = pw_y_s[k-1];
		end
		assign prod = acc_in * r_in;
		always_ff @(posedge clk) begin
			if (en) begin
				pw_acc_s[k]   <= (lss_pkg::POWER_W'(k) < range_power_q) ? prod[SW+15:16]
				                                                       : acc_in;
				pw_r_s[k]     <= r_in;
				pw_y_s[k]     <= y_in;
				pw_apart_s[k] <= apart_in;
			end
		end
	end

	// final stage: score = (1 - acc) * y
	logic [SW-1:0]   dfac;
	logic [2*SW-1:0] fin_prod;

	assign dfac     = SW'(lss_pkg::ONE_Q16 - pw_acc_s[NP-1]);
	assign fin_prod = dfac * pw_y_s[NP-1];

	always_ff @(posedge clk) begin
		if (en) begin
			fin_score_s <= fin_prod[SW+15:16];
			fin_apart_s <= pw_apart_s[NP-1];
		end
	end

	// valid chain through all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int j = 0; j < RL; j++) begin
				rt_v_s[j] <= 1'b0;
			end
			for (int k = 0; k < NP; k++) begin
				pw_v_s[k] <= 1'b0;
			end
			fin_v_s <= 1'b0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			rt_v_s[0] <= v_s3;
			for (int j = 1; j < RL; j++) begin
				rt_v_s[j] <= rt_v_s[j-1];
			end
			pw_v_s[0] <= rt_v_s[RL-1];
			for (int k = 1; k < NP; k++) begin
				pw_v_s[k] <= pw_v_s[k-1];
			end
			fin_v_s <= pw_v_s[NP-1];
		end
	end

	// two-entry output buffer, head in entry 0
	logic wr_hi;

	assign push  = en && fin_v_s;
	assign pop   = (obuf_cnt_q != 2'd0) && m_tready;
	assign wr_hi = (obuf_cnt_q == 2'd1) && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_cnt_q <= 2'd0;
		end else begin
			obuf_cnt_q <= obuf_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (obuf_cnt_q == 2'd2)) begin
			obuf_q[0] <= obuf_q[1];
		end
		if (push) begin
			if (wr_hi) begin
				obuf_q[1] <= {fin_apart_s, fin_score_s};
			end else begin
				obuf_q[0] <= {fin_apart_s, fin_score_s};
			end
		end
	end

	assign m_tvalid = obuf_cnt_q != 2'd0;
	assign m_tdata  = {6'b0, obuf_q[0]};

endmodule

// ===== test/link_stability_score_test.sv =====
// ----------------------------------------------------------------------------
// link_stability_score_test
// self-checking bench for the link stability scorer: a directed table and
// random neighbour pairs over several register settings, each result beat
// compared against a hand-worked score or an in-bench model of the score, under
// varied idling
`timescale 1ns / 1ps

module link_stability_score_test;

	localparam int VEL_W      = lss_pkg::VEL_W;
	localparam int POS_W      = lss_pkg::POS_W;
	localparam int SCORE_W    = lss_pkg::SCORE_W;
	localparam int RANGE_W    = lss_pkg::RANGE_W;
	localparam int SPEED_W    = lss_pkg::SPEED_W;
	localparam int POWER_W    = lss_pkg::POWER_W;
	localparam int QUO_W      = lss_pkg::QUO_W;
	localparam int ROOT_W     = lss_pkg::ROOT_W;
	localparam int POW_STAGES = lss_pkg::POW_STAGES;
	localparam int PAIR_W     = 6 * POS_W + 6 * VEL_W;

	// slave beat layout, first field in the lowest bits
	typedef struct packed {
		logic signed [VEL_W-1:0] peer_vz;
		logic signed [VEL_W-1:0] peer_vy;
		logic signed [VEL_W-1:0] peer_vx;
		logic signed [POS_W-1:0] peer_pz;
		logic signed [POS_W-1:0] peer_py;
		logic signed [POS_W-1:0] peer_px;
		logic signed [VEL_W-1:0] own_vz;
		logic signed [VEL_W-1:0] own_vy;
		logic signed [VEL_W-1:0] own_vx;
		logic signed [POS_W-1:0] own_pz;
		logic signed [POS_W-1:0] own_py;
		logic signed [POS_W-1:0] own_px;
	} pair_t;

	typedef struct {
		logic [SCORE_W-1:0] score;
		logic               apart;
	} score_t;

	// directed row: pair plus an optional hand-worked score
	typedef struct {
		pair_t              pair;
		bit                 typed;
		logic [SCORE_W-1:0] score;
		logic               apart;
	} row_t;

	localparam int DRAIN_CYCLES = 3 + 2 * (QUO_W + ROOT_W) + POW_STAGES + 40;
	localparam int PER_PHASE    = 250;
	localparam int N_PHASES     = 6;
	localparam logic signed [POS_W-1:0] PMAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] PMIN = 24'sh800000;
	localparam logic signed [VEL_W-1:0] VMAX = 20'sh7FFFF;
	localparam logic signed [VEL_W-1:0] VMIN = 20'sh80000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [22:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	// own_px, own_py, own_pz, own_vx, own_vy, own_vz,
	// peer_px, peer_py, peer_pz, peer_vx, peer_vy, peer_vz
	logic [263:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// score, moving_apart, zero fill
	logic [23:0]  m_tdata;

	// register copies held by the bench
	logic [RANGE_W-1:0] range_q;
	logic [SPEED_W-1:0] speed_q;
	logic [POWER_W-1:0] power_q;

	score_t pending_scores[$];
	int     beats_in   = 0;
	int     mismatches = 0;
	bit     failed     = 1'b0;
	int     send_idle_pct;
	int     recv_stall_pct;

	link_stability_score u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// floor(sqrt(num2/den2) * 65536), saturating at one
	function automatic longint unsigned len_ratio(longint unsigned num2,
			longint unsigned den2);
		longint unsigned rem, quo, root, t;
		rem  = num2;
		quo  = 0;
		root = 0;
		if (den2 == 0 || num2 >= den2)
			return 65536;
		for (int i = 0; i < QUO_W; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= den2) begin
				rem = rem - den2;
				quo = quo | 1;
			end
		end
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			t = root | (64'd1 << i);
			if (t * t <= quo)
				root = t;
		end
		return root;
	endfunction

	function automatic score_t stability_of(pair_t p);
		longint d[3], w[3];
		longint dot;
		longint unsigned d2, w2, r, acc, dfac, yfac, rl, sl;
		score_t s;
		d[0] = longint'(p.own_px) - longint'(p.peer_px);
		d[1] = longint'(p.own_py) - longint'(p.peer_py);
		d[2] = longint'(p.own_pz) - longint'(p.peer_pz);
		w[0] = longint'(p.own_vx) - longint'(p.peer_vx);
		w[1] = longint'(p.own_vy) - longint'(p.peer_vy);
		w[2] = longint'(p.own_vz) - longint'(p.peer_vz);
		d2  = 0;
		w2  = 0;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			d2  += longint'(d[i] * d[i]);
			w2  += longint'(w[i] * w[i]);
			dot += d[i] * w[i];
		end
		rl  = range_q;
		sl  = speed_q;
		r   = len_ratio(d2, rl * rl);
		acc = 65536;
		for (int k = 0; k < power_q; k++)
			acc = (acc * r) >> 16;
		dfac = 65536 - acc;
		// speed penalty only when the pair is drifting apart
		yfac = (dot > 0) ? 65536 - len_ratio(w2, 4 * sl * sl) : 65536;
		s.score = SCORE_W'((dfac * yfac) >> 16);
		s.apart = (dot > 0);
		return s;
	endfunction

	// offset around own position scaled to the current range
	function automatic pair_t random_pair();
		pair_t p;
		int    span, vspan;
		p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		if ($urandom_range(9) == 0)
			return p; // raw noise across every bit
		span  = int'(range_q) / 2 + 1;
		vspan = (speed_q > 262143) ? 262144 : int'(speed_q) + 1;
		if ($urandom_range(3) == 0)
			vspan = vspan / 8 + 1;
		p.peer_px = p.own_px + POS_W'(int'($urandom_range(2 * span)) - span);
		p.peer_py = p.own_py + POS_W'(int'($urandom_range(2 * span)) - span);
		p.peer_pz = p.own_pz + POS_W'(int'($urandom_range(2 * span)) - span);
		p.peer_vx = p.own_vx + VEL_W'(int'($urandom_range(2 * vspan)) - vspan);
		p.peer_vy = p.own_vy + VEL_W'(int'($urandom_range(2 * vspan)) - vspan);
		p.peer_vz = p.own_vz + VEL_W'(int'($urandom_range(2 * vspan)) - vspan);
		return p;
	endfunction

	// slave handshake bookkeeping and master beat checking
	always @(posedge clk) begin
		score_t want;
		if (s_tvalid && s_tready)
			beats_in <= beats_in + 1;
		if (m_tvalid && m_tready) begin
			if (pending_scores.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_tdata);
			end else begin
				want = pending_scores.pop_front();
				if (m_tdata[16:0] !== want.score || m_tdata[17] !== want.apart) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("score mismatch: want %0d/%0b got %0d/%0b",
							want.score, want.apart, m_tdata[16:0], m_tdata[17]);
				end
			end
		end
	end

	// receiver stalls at the rate of the current phase
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_reg(logic [1:0] idx, logic [22:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		unique case (idx)
			lss_pkg::REG_RANGE_LIMIT: range_q = val[RANGE_W-1:0];
			lss_pkg::REG_SPEED_LIMIT: speed_q = val[SPEED_W-1:0];
			default:                  power_q = val[POWER_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one slave beat; expectation queued when the beat is presented
	task automatic send_pair(pair_t p, score_t want);
		int seen;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		seen = beats_in;
		pending_scores.push_back(want);
		do @(negedge clk); while (beats_in == seen);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_scores.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		row_t  rows[$];
		row_t  r;
		pair_t z;
		int    cfg_set[N_PHASES][3];
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = lss_pkg::REG_RANGE_LIMIT;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		range_q        = 23'd4000;
		speed_q        = 19'd1280;
		power_q        = 4'd2;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, under reset settings
		z = '0;
		r = '{z, 1, 17'd65536, 0};                       rows.push_back(r); // coincident at origin
		r.pair = z; r.pair.own_px = PMAX; r.pair.peer_px = PMIN;
		r.score = 0; r.apart = 0;                         rows.push_back(r); // widest gap, still
		r.pair.own_vx = VMAX; r.pair.peer_vx = VMIN;
		r.apart = 1;                                      rows.push_back(r); // widest gap, fleeing
		r.pair = z; r.pair.own_px = 2000;
		r.score = 49152; r.apart = 0;                     rows.push_back(r); // half range
		r.pair.own_vx = 1280; r.score = 24576; r.apart = 1; rows.push_back(r); // half max speed, fleeing
		r.pair.own_vx = -1280; r.score = 49152; r.apart = 0; rows.push_back(r); // approaching
		r.pair = '{VMIN, VMIN, VMIN, PMIN, PMIN, PMIN, VMIN, VMIN, VMIN, PMIN, PMIN, PMIN};
		r.score = 17'd65536; r.apart = 0;                 rows.push_back(r); // coincident at min
		r.pair = z; r.pair.own_py = -4000;
		r.score = 0;                                      rows.push_back(r); // exactly at range
		r.typed = 0;
		r.pair = z; r.pair.own_pz = 3999; r.pair.own_vz = VMAX; r.pair.peer_vz = VMIN;
		rows.push_back(r);
		r.pair = z; r.pair.peer_py = PMAX; r.pair.peer_vy = VMAX; rows.push_back(r);
		r.pair = z; r.pair.own_px = 1; r.pair.own_vx = 1; rows.push_back(r);
		r.pair = z; r.pair.own_px = 1000; r.pair.own_py = -1000; r.pair.own_vz = 700;
		rows.push_back(r);
		foreach (rows[i])
			send_pair(rows[i].pair, rows[i].typed ? score_t'{rows[i].score, rows[i].apart}
				: stability_of(rows[i].pair));
		drain();

		// settings per phase: range, speed, exponent
		cfg_set = '{'{4000, 1280, 2}, '{1, 1, 1}, '{8388607, 524287, 8},
			'{0, 0, 0}, '{60000, 3000, 15},
			'{$urandom_range(8388607), $urandom_range(524287), $urandom_range(15)}};
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(lss_pkg::REG_RANGE_LIMIT, 23'(cfg_set[ph][0]));
			write_reg(lss_pkg::REG_SPEED_LIMIT, 23'(cfg_set[ph][1]));
			write_reg(lss_pkg::REG_RANGE_POWER, 23'(cfg_set[ph][2]));
			// idling mode rotates: none, sender, receiver, both
			unique case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < PER_PHASE; n++) begin
				pair_t p;
				p = random_pair();
				send_pair(p, stability_of(p));
				// mid-phase hold-off until the pipeline has emptied
				if (n == PER_PHASE / 2 && ph == 2) begin
					s_tvalid <= 1'b0;
					while (pending_scores.size() != 0)
						@(negedge clk);
				end
			end
			drain();
		end

		if (!failed && pending_scores.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
